[hw/rtl/rhl_pkg.sv]
`timescale 1ns / 1ps

package rhl_pkg;

  // Fixed-point fraction bits of the linear values, coefficients and XYZ.
  localparam int FRAC_BITS = 16;

  localparam int LIN_W   = FRAC_BITS + 7;   // linear value times 100, below 128.0
  localparam int COEF_W  = FRAC_BITS + 1;   // matrix coefficient, at most 1.0
  localparam int PROD_W  = LIN_W + COEF_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int XYZ_W   = FRAC_BITS + 7;
  localparam int SQ_W    = FRAC_BITS + 4;   // root of Y, below 16.0
  localparam int SQ_IN_W = 2 * SQ_W;
  localparam int NUM_W   = FRAC_BITS + 25;  // signed numerators of a and b
  localparam int DEN_W   = FRAC_BITS + 14;  // 1000 times the root
  localparam int Q_BITS  = 9;               // quotient bits below the overflow check
  localparam int DIV_LAT = Q_BITS + 1;

  localparam int L_W    = 7;
  localparam int AB_W   = 10;
  localparam int L_MAX  = 100;
  localparam int AB_MIN = -128;
  localparam int AB_MAX = 383;
  localparam int AB_MID = 128;

  localparam int QB = 30;

  typedef logic [LIN_W-1:0] lin_rom_t [256];
  typedef logic [COEF_W-1:0] coef_arr_t [9];

  // Data that rides along the square root pipeline.
  typedef struct packed {
    logic signed [NUM_W-1:0] pa;
    logic signed [NUM_W-1:0] pb;
    logic                    yzero;
  } rhl_side_t;

  // Fifth power in Q30, truncated after each product.
  function automatic longint unsigned pow5_q(longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) begin
      p = (p * r) >> QB;
    end
    return p;
  endfunction

  // sRGB to linear table, built at elaboration.
  function automatic lin_rom_t build_lin_rom();
    lin_rom_t rom;
    longint unsigned t;
    longint unsigned s;
    longint unsigned p;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned cl;
    for (int c = 0; c < 256; c++) begin
      cl = longint'(c);
      if (c <= 10) begin
        rom[c] = LIN_W'((cl * 64'd10000 * (64'd1 << FRAC_BITS)) / 64'd329460);
      end else begin
        t  = ((64'd1000 * cl + 64'd14025) << QB) / 64'd269025;
        s  = (t * t) >> QB;
        lo = 0;
        hi = 64'd1 << QB;
        while (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (pow5_q(mid) <= s) lo = mid;
          else hi = mid - 64'd1;
        end
        p = (s * lo) >> QB;
        rom[c] = LIN_W'((p * 64'd100) >> (QB - FRAC_BITS));
      end
    end
    return rom;
  endfunction

  function automatic logic [COEF_W-1:0] cq(int k);
    return COEF_W'(((longint'(k) << FRAC_BITS) + 64'd5000) / 64'd10000);
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin_rom();

  // Rows X, Y, Z; columns R, G, B.
  localparam coef_arr_t COEF = '{cq(4124), cq(3576), cq(1805),
                                 cq(2126), cq(7152), cq(722),
                                 cq(193),  cq(1192), cq(9505)};

endpackage

[hw/rtl/rgb_to_hunter_lab.sv]
`timescale 1ns / 1ps
// Throughput: one pixel per cycle; the square root and the two dividers are
// pipelined one bit per stage, so a new word enters every cycle unless the output stalls.
// A stalled output holds the whole pipeline in place.
// Reset clears only the valid bits; data registers are not reset.
module rgb_to_hunter_lab (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // lightness [6:0], hunter_a [16:7], hunter_b [26:17], zeros
);

  localparam int F  = rhl_pkg::FRAC_BITS;
  localparam int NW = rhl_pkg::NUM_W;
  localparam int DL = rhl_pkg::DIV_LAT;
  localparam int VL = rhl_pkg::SQ_W + DL + 6;

  localparam logic signed [NW-1:0] K_AX = NW'(17850);
  localparam logic signed [NW-1:0] K_AY = NW'(17500);
  localparam logic signed [NW-1:0] K_BY = NW'(7000);
  localparam logic signed [NW-1:0] K_BZ = NW'(5929);

  logic          en;
  logic [VL-1:0] vld_r;

  logic [rhl_pkg::LIN_W-1:0]  lin_r  [3];
  logic [rhl_pkg::PROD_W-1:0] prod_r [9];
  logic [rhl_pkg::XYZ_W-1:0]  xyz_r  [3];

  logic [rhl_pkg::SQ_IN_W-1:0] pre_val_r;
  rhl_pkg::rhl_side_t          pre_side_r;
  logic signed [NW-1:0]        pa_nxt;
  logic signed [NW-1:0]        pb_nxt;

  logic [rhl_pkg::SQ_W-1:0]  root;
  rhl_pkg::rhl_side_t        root_side;
  logic [rhl_pkg::DEN_W-1:0] den_r;
  logic [rhl_pkg::DEN_W-1:0] den_nxt;
  logic signed [NW-1:0]      na_r;
  logic signed [NW-1:0]      nb_r;
  logic [rhl_pkg::L_W-1:0]   l_r;
  logic [rhl_pkg::L_W-1:0]   l_nxt;
  logic [F+7:0]              l_wide;
  logic                      yz_r;

  logic [rhl_pkg::L_W-1:0]         l_dly_r  [DL];
  logic                            yz_dly_r [DL];
  logic signed [rhl_pkg::AB_W-1:0] a_q;
  logic signed [rhl_pkg::AB_W-1:0] b_q;
  logic [31:0]                     out_r;

  // The pipeline moves unless the output word is held; no word is taken in reset.
  assign en         = !vld_r[VL-1] || out_tready;
  assign in_tready  = en && rst_n;
  assign out_tvalid = vld_r[VL-1];
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[VL-2:0], in_tvalid};
    end
  end

  // Linearize, multiply by the matrix, then sum each row.
  always_ff @(posedge clk) begin
    if (en) begin
      lin_r[0] <= rhl_pkg::LIN_ROM[in_tdata[7:0]];
      lin_r[1] <= rhl_pkg::LIN_ROM[in_tdata[15:8]];
      lin_r[2] <= rhl_pkg::LIN_ROM[in_tdata[23:16]];
      for (int i = 0; i < 9; i++) begin
        prod_r[i] <= rhl_pkg::PROD_W'(lin_r[i % 3]) * rhl_pkg::PROD_W'(rhl_pkg::COEF[i]);
      end
      for (int j = 0; j < 3; j++) begin
        xyz_r[j] <= rhl_pkg::XYZ_W'((rhl_pkg::SUM_W'(prod_r[3*j])
                                   + rhl_pkg::SUM_W'(prod_r[3*j+1])
                                   + rhl_pkg::SUM_W'(prod_r[3*j+2])) >> F);
      end
    end
  end

  // Numerator parts that do not need the root.
  always_comb begin
    pa_nxt = K_AX * NW'(xyz_r[0]) - K_AY * NW'(xyz_r[1]);
    pb_nxt = K_BY * NW'(xyz_r[1]) - K_BZ * NW'(xyz_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_val_r        <= rhl_pkg::SQ_IN_W'({xyz_r[1], {F{1'b0}}});
      pre_side_r.pa    <= pa_nxt;
      pre_side_r.pb    <= pb_nxt;
      pre_side_r.yzero <= xyz_r[1] == '0;
    end
  end

  rhl_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .in_val   (pre_val_r),
    .in_side  (pre_side_r),
    .out_root (root),
    .out_side (root_side)
  );

  // Denominator, offset numerators and lightness.
  always_comb begin
    den_nxt = rhl_pkg::DEN_W'(root) * rhl_pkg::DEN_W'(1000);
    l_wide  = ((F+8)'(root) * (F+8)'(10)) >> F;
    l_nxt   = (l_wide > (F+8)'(rhl_pkg::L_MAX)) ? rhl_pkg::L_W'(rhl_pkg::L_MAX)
                                                : l_wide[rhl_pkg::L_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den_nxt;
      na_r  <= root_side.pa + (NW'(den_nxt) << 7);
      nb_r  <= root_side.pb + (NW'(den_nxt) << 7);
      l_r   <= l_nxt;
      yz_r  <= root_side.yzero;
    end
  end

  rhl_div u_div_a (
    .clk    (clk),
    .en     (en),
    .num    (na_r),
    .den    (den_r),
    .result (a_q)
  );

  rhl_div u_div_b (
    .clk    (clk),
    .en     (en),
    .num    (nb_r),
    .den    (den_r),
    .result (b_q)
  );

  // Lightness and the zero flag wait for the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      l_dly_r[0]  <= l_r;
      yz_dly_r[0] <= yz_r;
      for (int i = 1; i < DL; i++) begin
        l_dly_r[i]  <= l_dly_r[i-1];
        yz_dly_r[i] <= yz_dly_r[i-1];
      end
    end
  end

  // Output word; zero luminance gives a neutral result.
  always_ff @(posedge clk) begin
    if (en) begin
      if (yz_dly_r[DL-1]) begin
        out_r <= {5'b0, rhl_pkg::AB_W'(rhl_pkg::AB_MID), rhl_pkg::AB_W'(rhl_pkg::AB_MID),
                  rhl_pkg::L_W'(0)};
      end else begin
        out_r <= {5'b0, b_q, a_q, l_dly_r[DL-1]};
      end
    end
  end

endmodule

[hw/rtl/rhl_sqrt.sv]
`timescale 1ns / 1ps

// Restoring square root, one result bit per register stage.
module rhl_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rhl_pkg::SQ_IN_W-1:0] in_val,
  input  rhl_pkg::rhl_side_t          in_side,
  output logic [rhl_pkg::SQ_W-1:0]    out_root,
  output rhl_pkg::rhl_side_t          out_side
);

  localparam int N  = rhl_pkg::SQ_W;
  localparam int VW = rhl_pkg::SQ_IN_W;

  logic [N:0]    rem_r  [N];
  logic [N-1:0]  root_r [N];
  logic [VW-1:0] val_r  [N];
  rhl_pkg::rhl_side_t side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [N:0]    rem_prev;
    logic [N-1:0]  root_prev;
    logic [VW-1:0] val_prev;
    rhl_pkg::rhl_side_t side_prev;
    logic [N+2:0]  rem_sh;
    logic [N+2:0]  trial;
    logic          ge;
    logic [N:0]    rem_nxt;
    logic [N-1:0]  root_nxt;

    // The first stage starts from the input, the others from the stage before.
    if (k == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign val_prev  = in_val;
      assign side_prev = in_side;
    end else begin : g_next
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
      assign val_prev  = val_r[k-1];
      assign side_prev = side_r[k-1];
    end

    // Bring down the next two bits and try a one in the root.
    always_comb begin
      rem_sh   = {rem_prev, val_prev[VW-1 -: 2]};
      trial    = {1'b0, root_prev, 2'b01};
      ge       = rem_sh >= trial;
      rem_nxt  = ge ? (N+1)'(rem_sh - trial) : rem_sh[N:0];
      root_nxt = {root_prev[N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        val_r[k]  <= {val_prev[VW-3:0], 2'b00};
        side_r[k] <= side_prev;
      end
    end
  end

  assign out_root = root_r[N-1];
  assign out_side = side_r[N-1];

endmodule

[hw/rtl/rhl_div.sv]
`timescale 1ns / 1ps

// Signed divide truncating toward zero, one quotient bit per stage,
// saturated to the a and b range.
module rhl_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [rhl_pkg::NUM_W-1:0] num,
  input  logic [rhl_pkg::DEN_W-1:0]        den,
  output logic signed [rhl_pkg::AB_W-1:0]  result
);

  localparam int NW = rhl_pkg::NUM_W;
  localparam int QN = rhl_pkg::Q_BITS;

  logic [NW-1:0]                rem_r [QN+1];
  logic [NW-1:0]                den_r [QN+1];
  logic [QN-1:0]                q_r   [QN+1];
  logic                         neg_r [QN+1];
  logic                         ovf_r [QN+1];

  logic [NW-1:0] mag;
  logic [NW-1:0] den_x;

  // Magnitude and overflow check against the full quotient range.
  always_comb begin
    mag   = num[NW-1] ? NW'(-num) : NW'(num);
    den_x = NW'(den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= mag;
      den_r[0] <= den_x;
      q_r[0]   <= '0;
      neg_r[0] <= num[NW-1];
      ovf_r[0] <= mag >= (den_x << QN);
    end
  end

  for (genvar k = 0; k < QN; k++) begin : g_step
    logic [NW-1:0] dsh;
    logic          ge;

    // Quotient bit QN-1-k.
    always_comb begin
      dsh = den_r[k] << (QN - 1 - k);
      ge  = rem_r[k] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? rem_r[k] - dsh : rem_r[k];
        den_r[k+1] <= den_r[k];
        q_r[k+1]   <= q_r[k] | (QN'(ge) << (QN - 1 - k));
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  // Sign and saturation.
  always_comb begin
    if (neg_r[QN]) begin
      if (ovf_r[QN] || q_r[QN] > QN'(-rhl_pkg::AB_MIN)) begin
        result = rhl_pkg::AB_W'(rhl_pkg::AB_MIN);
      end else begin
        result = -rhl_pkg::AB_W'(q_r[QN]);
      end
    end else begin
      if (ovf_r[QN] || q_r[QN] > QN'(rhl_pkg::AB_MAX)) begin
        result = rhl_pkg::AB_W'(rhl_pkg::AB_MAX);
      end else begin
        result = rhl_pkg::AB_W'(q_r[QN]);
      end
    end
  end

endmodule

[sim/tb_rgb_to_hunter_lab.sv]
`timescale 1ns / 1ps

module tb_rgb_to_hunter_lab;

  localparam int LATENCY   = 36;
  localparam int MAX_CYCLE = 400000;
  localparam int N_RANDOM  = 500;
  localparam int N_DIRECT  = 14;

  // One converted pixel, laid out as in the output word (lightness lowest).
  typedef struct packed {
    logic signed [9:0] hunter_b;
    logic signed [9:0] hunter_a;
    logic [6:0]        lightness;
  } lab_t;

  // One row of the directed table; known marks an expectation typed in by hand.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       known;
    lab_t       lab;
  } pixel_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  rgb_to_hunter_lab u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Linearization table and matrix, held at 64 bits for the arithmetic below.
  longint unsigned lin_table [256];
  longint unsigned mat [9];
  lab_t            pending_lab [$];
  lab_t            hand_lab [$];
  logic            hand_known [$];
  int              errors;
  int              cycles;
  bit              feeding_done;
  bit              hold_off;

  function automatic longint unsigned fifth_power(longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) p = (p * r) >> 30;
    return p;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_ab(longint v);
    if (v < rhl_pkg::AB_MIN) return rhl_pkg::AB_MIN;
    if (v > rhl_pkg::AB_MAX) return rhl_pkg::AB_MAX;
    return v;
  endfunction

  // Builds the sRGB decoding table and the rounded XYZ matrix.
  task automatic fill_tables();
    longint unsigned t, s, p, lo, hi, mid, cl;
    int              coefs [9];
    coefs = '{4124, 3576, 1805, 2126, 7152, 722, 193, 1192, 9505};
    for (int k = 0; k < 9; k++) begin
      mat[k] = ((longint'(coefs[k]) << rhl_pkg::FRAC_BITS) + 64'd5000) / 64'd10000;
    end
    for (int c = 0; c < 256; c++) begin
      cl = c;
      if (c <= 10) begin
        lin_table[c] = (cl * 64'd10000 * (64'd1 << rhl_pkg::FRAC_BITS)) / 64'd329460;
      end else begin
        t  = ((64'd1000 * cl + 64'd14025) << 30) / 64'd269025;
        s  = (t * t) >> 30;
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (fifth_power(mid) <= s) lo = mid;
          else hi = mid - 64'd1;
        end
        p = (s * lo) >> 30;
        lin_table[c] = (p * 64'd100) >> (30 - rhl_pkg::FRAC_BITS);
      end
    end
  endtask

  // Converts one pixel to Hunter Lab.
  function automatic lab_t hunter_lab_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint unsigned lr, lg, lb, xv, yv, zv, root, lval;
    longint          den, av, bv;
    lab_t            res;
    lr = lin_table[r];
    lg = lin_table[g];
    lb = lin_table[b];
    xv = (lr * mat[0] + lg * mat[1] + lb * mat[2]) >> rhl_pkg::FRAC_BITS;
    yv = (lr * mat[3] + lg * mat[4] + lb * mat[5]) >> rhl_pkg::FRAC_BITS;
    zv = (lr * mat[6] + lg * mat[7] + lb * mat[8]) >> rhl_pkg::FRAC_BITS;
    root = int_sqrt(yv << rhl_pkg::FRAC_BITS);
    // Zero luminance gives a neutral gray at black.
    if (yv == 0 || root == 0) begin
      res.lightness = '0;
      res.hunter_a  = 10'(rhl_pkg::AB_MID);
      res.hunter_b  = 10'(rhl_pkg::AB_MID);
      return res;
    end
    lval = (64'd10 * root) >> rhl_pkg::FRAC_BITS;
    if (lval > rhl_pkg::L_MAX) lval = 64'(rhl_pkg::L_MAX);
    den = 1000 * longint'(root);
    av  = (175 * (102 * longint'(xv) - 100 * longint'(yv)) + 128 * den) / den;
    bv  = (7 * (1000 * longint'(yv) - 847 * longint'(zv)) + 128 * den) / den;
    res.lightness = lval[6:0];
    res.hunter_a  = 10'(clamp_ab(av));
    res.hunter_b  = 10'(clamp_ab(bv));
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Offers one pixel and waits for it to be taken; records its expectation.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic known, lab_t typed);
    lab_t want;
    want = hunter_lab_of(r, g, b);
    pending_lab = {pending_lab, want};
    hand_known  = {hand_known, known};
    hand_lab    = {hand_lab, typed};
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic pause_sender();
    in_tvalid <= 1'b0;
    in_tdata  <= 24'($urandom);
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // Sender: directed table, then random bursts.
  initial begin
    pixel_row_t rows [N_DIRECT];
    lab_t       neutral;
    int         burst;
    int         kind;
    logic [7:0] r, g, b;
    neutral = '{lightness: 7'd0, hunter_a: 10'sd128, hunter_b: 10'sd128};
    rows = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, neutral},
      '{8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{8'd255, 8'd0,   8'd0,   1'b0, '0},
      '{8'd0,   8'd255, 8'd0,   1'b0, '0},
      '{8'd0,   8'd0,   8'd255, 1'b0, '0},
      '{8'd1,   8'd0,   8'd0,   1'b0, '0},
      '{8'd0,   8'd0,   8'd1,   1'b0, '0},
      '{8'd0,   8'd1,   8'd0,   1'b0, '0},
      '{8'd10,  8'd10,  8'd10,  1'b0, '0},
      '{8'd11,  8'd11,  8'd11,  1'b0, '0},
      '{8'd255, 8'd0,   8'd255, 1'b0, '0},
      '{8'd0,   8'd255, 8'd255, 1'b0, '0},
      '{8'd170, 8'd85,  8'd170, 1'b0, '0},
      '{8'd85,  8'd170, 8'd85,  1'b0, '0}
    };
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    feeding_done = 1'b0;
    fill_tables();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      send_pixel(rows[i].red, rows[i].green, rows[i].blue, rows[i].known, rows[i].lab);
      if ($urandom_range(0, 2) == 0) pause_sender();
    end
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = int'($urandom_range(0, 9));
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      // Mix of dark pixels, grays and saturated corners with the general case.
      if (kind == 0) begin
        r = 8'($urandom_range(0, 12));
        g = 8'($urandom_range(0, 12));
        b = 8'($urandom_range(0, 12));
      end else if (kind == 1) begin
        g = r;
        b = r;
      end else if (kind == 2) begin
        r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      send_pixel(r, g, b, 1'b0, '0);
      if (burst == 0) begin
        burst = int'($urandom_range(1, 40));
        if (n > 100) pause_sender();
      end else begin
        burst--;
      end
    end
    in_tvalid    <= 1'b0;
    feeding_done <= 1'b1;
  end

  // Receiver stall pattern, with one long hold-off early on.
  initial begin
    hold_off = 1'b0;
    @(posedge rst_n);
    repeat (60) @(posedge clk);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else if (cycles % 400 < 150) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // Compare each output word with the oldest expectation.
  always @(posedge clk) begin
    lab_t got, want;
    lab_t typed;
    logic known;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[26:0];
      if (pending_lab.size() == 0) begin
        $display("unexpected output word at cycle %0d", cycles);
        errors++;
      end else begin
        want  = pending_lab.pop_front();
        known = hand_known.pop_front();
        typed = hand_lab.pop_front();
        if (known) want = typed;
        if (got.lightness != want.lightness)
          report_mismatch("lightness", got.lightness, want.lightness);
        if (got.hunter_a != want.hunter_a)
          report_mismatch("hunter_a", got.hunter_a, want.hunter_a);
        if (got.hunter_b != want.hunter_b)
          report_mismatch("hunter_b", got.hunter_b, want.hunter_b);
        if (out_tdata[31:27] != '0) report_mismatch("padding", out_tdata[31:27], 0);
      end
    end
  end

  // Cycle limit.
  initial begin
    errors = 0;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= MAX_CYCLE) begin
        $display("** rgb_to_hunter_lab: FAILED **");
        $finish;
      end
    end
  end

  // End of run: drain, then idle in quiet cycles before the verdict.
  initial begin
    @(posedge rst_n);
    wait (feeding_done);
    while (pending_lab.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("** rgb_to_hunter_lab: PASSED **");
    end else begin
      $display("** rgb_to_hunter_lab: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/rhl_pkg.sv
hw/rtl/rhl_sqrt.sv
hw/rtl/rhl_div.sv
hw/rtl/rgb_to_hunter_lab.sv
sim/tb_rgb_to_hunter_lab.sv
